// ----- rtl/fifo_queue_with_search_defines.svh -----
// Assertion macros for the checker file of the queue block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FQS_CHECK(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FQS_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/fqs_pkg.sv -----
// Shared types and codes of the queue-with-search block.
// No dependencies; used by the storage module, the top level and the checker.
`default_nettype none

package fqs_pkg;

   localparam int WORD_W = 32;

   typedef logic [1:0]              opcode_type;
   typedef logic [1:0]              status_type;
   typedef logic signed [WORD_W-1:0] word_type;

   localparam opcode_type OP_ENQUEUE = 2'd0;
   localparam opcode_type OP_DEQUEUE = 2'd1;
   localparam opcode_type OP_SEARCH  = 2'd2;
   localparam opcode_type OP_CLEAR   = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   // Port enables of the entry memory.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/fqs_store.sv -----
// Entry memory of the queue: one write port, one read port with registered data.
// Depends on fqs_pkg.
`default_nettype none

module fqs_store #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                               clock,
   input  wire fqs_pkg::mem_ctl_type               mem_ctl,
   input  wire logic [$clog2(QUEUE_DEPTH)-1:0]     wr_addr,
   input  wire fqs_pkg::word_type                  wr_data,
   input  wire logic [$clog2(QUEUE_DEPTH)-1:0]     rd_addr,
   output fqs_pkg::word_type                       rd_data
);
   import fqs_pkg::*;

   word_type mem_ff [QUEUE_DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/fifo_queue_with_search.sv -----
// A bounded first-in first-out queue of signed 32-bit values with a membership
// search. An item is taken when start is high and busy is low; its single result
// is shown on the rsp_ ports for exactly one cycle, marked by rsp_strobe, in the
// cycle after the item's last working cycle, and the receiver cannot hold it off.
// Enqueue, clear and any rejected operation leave busy low, so a new item may be
// started in the very next cycle. A dequeue passes through S_DEQUEUE because
// the entry memory returns its read data in the cycle after the address. A
// search walks the stored values from the front through the memory's single
// read port and one shared comparator, one entry per cycle: on an empty queue
// it stays idle, and otherwise it passes through S_SCAN until the first hit or
// the last stored entry. The memory content is not reset; only entries between
// the front and back indices are ever read.
// Depends on fqs_pkg and fqs_store.
`default_nettype none

module fifo_queue_with_search #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output      logic                                 busy,
   input  wire fqs_pkg::opcode_type                  req_opcode,
   input  wire fqs_pkg::word_type                    req_item_value,
   output      logic                                 rsp_strobe,
   output fqs_pkg::word_type                         rsp_read_value,
   output      logic                                 rsp_found,
   output fqs_pkg::status_type                       rsp_status,
   output      logic [$clog2(QUEUE_DEPTH+1)-1:0]     rsp_occupancy
);
   import fqs_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(QUEUE_DEPTH - 1);

   // Sequencer states.
   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_DEQUEUE = 2'd1;
   localparam logic [1:0] S_SCAN    = 2'd2;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      next_slot = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
   endfunction

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0] scan_left_ff, scan_left_in;
   word_type         value_ff, value_in;

   logic             rsp_strobe_ff, rsp_strobe_in;
   word_type         rsp_read_value_ff, rsp_read_value_in;
   logic             rsp_found_ff, rsp_found_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0] rsp_occupancy_ff, rsp_occupancy_in;

   mem_ctl_type      mem_ctl;
   logic [IDX_W-1:0] rd_addr;
   word_type         rd_data;
   logic             accept;
   logic             match;

   fqs_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (back_ff),
      .wr_data (req_item_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // The one comparator, shared by every step of a search.
   assign match = (rd_data == value_ff);

   always_comb begin
      state_in          = state_ff;
      front_in          = front_ff;
      back_in           = back_ff;
      count_in          = count_ff;
      scan_idx_in       = scan_idx_ff;
      scan_left_in      = scan_left_ff;
      value_in          = value_ff;
      mem_ctl           = '0;
      rd_addr           = front_ff;
      rsp_strobe_in     = 1'b0;
      rsp_read_value_in = '0;
      rsp_found_in      = 1'b0;
      rsp_status_in     = ST_OK;
      rsp_occupancy_in  = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in = req_item_value;
               case (req_opcode)
                  OP_ENQUEUE: begin
                     rsp_strobe_in = 1'b1;
                     if (count_ff == FULL_COUNT) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_ctl.wr_en    = 1'b1;
                        back_in          = next_slot(back_ff);
                        count_in         = count_ff + CNT_W'(1);
                        rsp_occupancy_in = count_in;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        // Front entry is read now; its data arrives next cycle.
                        mem_ctl.rd_en = 1'b1;
                        front_in      = next_slot(front_ff);
                        count_in      = count_ff - CNT_W'(1);
                        state_in      = S_DEQUEUE;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        scan_idx_in   = next_slot(front_ff);
                        scan_left_in  = count_ff;
                        state_in      = S_SCAN;
                     end
                  end
                  default: begin
                     // Clear: the stored entries become unreachable.
                     front_in         = '0;
                     back_in          = '0;
                     count_in         = '0;
                     rsp_strobe_in    = 1'b1;
                     rsp_occupancy_in = '0;
                  end
               endcase
            end
         end
         S_DEQUEUE: begin
            rsp_strobe_in     = 1'b1;
            rsp_read_value_in = rd_data;
            state_in          = S_IDLE;
         end
         S_SCAN: begin
            // Compare the entry read last cycle; stop at a hit or the last entry.
            if (match || scan_left_ff == CNT_W'(1)) begin
               rsp_strobe_in = 1'b1;
               rsp_found_in  = match;
               state_in      = S_IDLE;
            end else begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = scan_idx_ff;
               scan_idx_in   = next_slot(scan_idx_ff);
               scan_left_in  = scan_left_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         front_ff      <= '0;
         back_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         back_ff       <= back_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff       <= scan_idx_in;
      scan_left_ff      <= scan_left_in;
      value_ff          <= value_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_occupancy_ff  <= rsp_occupancy_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;

endmodule

`default_nettype wire

// ----- rtl/fqs_checker.sv -----
// Port-level checker of the queue block and the bind that attaches it.
// Depends on fqs_pkg and fifo_queue_with_search_defines.svh.
`default_nettype none

`include "fifo_queue_with_search_defines.svh"

module fqs_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic                             rsp_strobe,
   input wire logic                             rsp_found,
   input wire fqs_pkg::status_type              rsp_status,
   input wire logic [$clog2(QUEUE_DEPTH+1)-1:0] rsp_occupancy
);
   import fqs_pkg::*;

   localparam logic [$clog2(QUEUE_DEPTH+1)-1:0] FULL_COUNT =
      ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH);

   // An accepted item either keeps the block busy or answers at once.
   `FQS_CHECK_NEXT(a_accept_progress, clock, reset,
      start && !busy, busy || rsp_strobe, "item dropped")
   // A multi-cycle item ends exactly when its result is shown.
   `FQS_CHECK(a_finish_result, clock, reset,
      $fell(busy), rsp_strobe, "busy fell without result")
   `FQS_CHECK(a_empty_count, clock, reset,
      rsp_strobe && rsp_status == ST_EMPTY, rsp_occupancy == '0, "empty status with items")
   `FQS_CHECK(a_full_count, clock, reset,
      rsp_strobe && rsp_status == ST_FULL, rsp_occupancy == FULL_COUNT,
      "full status below depth")
   `FQS_CHECK(a_found_nonempty, clock, reset,
      rsp_strobe && rsp_found, rsp_occupancy != '0 && rsp_status == ST_OK,
      "hit in empty queue")

endmodule

bind fifo_queue_with_search fqs_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fqs_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_found     (rsp_found),
   .rsp_status    (rsp_status),
   .rsp_occupancy (rsp_occupancy)
);

`default_nettype wire

// ----- tb/tb_fifo_queue_with_search.sv -----
// Self-checking testbench for fifo_queue_with_search: a directed opening, then
// random enqueue, dequeue, search and clear traffic checked against a predictor.
// Depends on fqs_pkg and the fifo_queue_with_search RTL; reads no files.
`timescale 1ns / 100ps

module tb_fifo_queue_with_search;
   import fqs_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ITEM_TARGET = 1500;

   // One result of the block as the predictor expects it.
   typedef struct packed {
      word_type         read_value;
      logic             found;
      status_type       status;
      logic [OCC_W-1:0] occupancy;
   } response_type;

   // The predictor keeps its own circular buffer and indices, works out the
   // result of every accepted item and queues it until the block answers.
   class fifo_search_predictor;
      word_type       slots[QUEUE_DEPTH];
      int unsigned    head_idx;
      int unsigned    tail_idx;
      int unsigned    count;
      response_type   pending_results[$];
      int unsigned    mismatches;

      function void note_request(opcode_type op, word_type value);
         response_type rsp;
         int unsigned  idx;
         rsp = '0;
         case (op)
            OP_ENQUEUE: begin
               if (count >= QUEUE_DEPTH) begin
                  rsp.status = ST_FULL;
               end else begin
                  slots[tail_idx] = value;
                  tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
                  count++;
               end
            end
            OP_DEQUEUE: begin
               if (count == 0) begin
                  rsp.status = ST_EMPTY;
               end else begin
                  rsp.read_value = slots[head_idx];
                  head_idx = (head_idx + 1) % QUEUE_DEPTH;
                  count--;
               end
            end
            OP_SEARCH: begin
               idx = head_idx;
               for (int k = 0; k < count; k++) begin
                  if (slots[idx] == value) begin
                     rsp.found = 1'b1;
                  end
                  idx = (idx + 1) % QUEUE_DEPTH;
               end
            end
            default: begin
               head_idx = 0;
               tail_idx = 0;
               count = 0;
            end
         endcase
         rsp.occupancy = count[OCC_W-1:0];
         pending_results.push_back(rsp);
      endfunction

      function void check_response(word_type read_value, logic found, status_type status,
                                   logic [OCC_W-1:0] occupancy);
         response_type want;
         if (pending_results.size() == 0) begin
            $error("result arrived with no item outstanding");
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         if (read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value, read_value);
            mismatches++;
         end
         if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            mismatches++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
         if (occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, occupancy);
            mismatches++;
         end
      endfunction

      // A value currently held in the queue, so that searches can hit.
      function word_type stored_value();
         if (count == 0) begin
            return word_type'($urandom);
         end
         return slots[(head_idx + $urandom_range(count - 1)) % QUEUE_DEPTH];
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   opcode_type       req_opcode;
   word_type         req_item_value;
   logic             rsp_strobe;
   word_type         rsp_read_value;
   logic             rsp_found;
   status_type       rsp_status;
   logic [OCC_W-1:0] rsp_occupancy;

   fifo_search_predictor predictor;
   int unsigned          items_sent;
   int unsigned          idle_percent;

   fifo_queue_with_search #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_item_value(req_item_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_read_value(rsp_read_value),
      .rsp_found     (rsp_found),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   // Everything is sampled at the rising edge, before the block's own registers
   // update. A result always belongs to an item accepted at an earlier edge, so
   // checking before noting the new item keeps the expected order intact.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            predictor.check_response(rsp_read_value, rsp_found, rsp_status, rsp_occupancy);
         end
         if (start && !busy) begin
            predictor.note_request(req_opcode, req_item_value);
         end
      end
   end

   // Lowers start for a few cycles. Only called between items, so start is
   // never dropped and raised again at the same falling edge.
   task automatic idle_gap(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
         req_opcode <= opcode_type'($urandom);
         req_item_value <= word_type'($urandom);
      end
   endtask

   // Presents one item at the falling edge and holds it until an edge where
   // busy is low takes it. Start stays high if the next item follows at once.
   task automatic issue(opcode_type op, word_type value);
      if ($urandom_range(99) < idle_percent) begin
         idle_gap($urandom_range(1, 4));
      end
      @(negedge clock);
      start <= 1'b1;
      req_opcode <= op;
      req_item_value <= value;
      do begin
         @(posedge clock);
      end while (busy);
      items_sent++;
   endtask

   // Values lean toward small numbers and the extremes so that duplicates and
   // sign-bit cases show up, while plain random words toggle every bit.
   function automatic word_type random_word();
      case ($urandom_range(3))
         0: return word_type'($urandom_range(7)) - 4;
         1: begin
            case ($urandom_range(3))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return word_type'($urandom);
      endcase
   endfunction

   // One random burst. Fill and drain bursts walk the queue between empty and
   // full, so the indices wrap; searches mostly look for stored values.
   task automatic random_burst();
      int unsigned n;
      int unsigned pick;
      pick = $urandom_range(19);
      if (pick < 8) begin
         n = $urandom_range(1, 20);
         repeat (n) issue(OP_ENQUEUE, random_word());
      end else if (pick < 13) begin
         n = $urandom_range(1, 20);
         repeat (n) issue(OP_DEQUEUE, random_word());
      end else if (pick < 18) begin
         n = $urandom_range(1, 6);
         repeat (n) begin
            if ($urandom_range(99) < 65) begin
               issue(OP_SEARCH, predictor.stored_value());
            end else begin
               issue(OP_SEARCH, random_word());
            end
         end
      end else if (pick == 18) begin
         issue(OP_CLEAR, word_type'($urandom));
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) issue(opcode_type'($urandom), word_type'($urandom));
      end
   endtask

   initial begin
      int unsigned idle_plan[5];
      predictor = new;
      items_sent = 0;
      idle_percent = 0;
      idle_plan = '{0, 86, 17, 0, 86};
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_ENQUEUE;
      req_item_value = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed opening: empty-queue cases, extreme values, a hit at the
      // front and at the back, a miss, a clear and a drain back to empty.
      issue(OP_DEQUEUE, 32'sh7FFF_FFFF);
      issue(OP_SEARCH, '0);
      issue(OP_ENQUEUE, 32'sh8000_0000);
      issue(OP_ENQUEUE, 32'sh7FFF_FFFF);
      issue(OP_ENQUEUE, 32'shAAAA_AAAA);
      issue(OP_ENQUEUE, 32'sh5555_5555);
      issue(OP_SEARCH, 32'sh8000_0000);
      issue(OP_SEARCH, 32'sh5555_5555);
      issue(OP_SEARCH, '0);
      issue(OP_DEQUEUE, '0);
      issue(OP_SEARCH, 32'sh8000_0000);
      issue(OP_CLEAR, '1);
      issue(OP_SEARCH, 32'sh7FFF_FFFF);
      issue(OP_ENQUEUE, '0);
      issue(OP_ENQUEUE, '1);
      issue(OP_SEARCH, '1);
      issue(OP_DEQUEUE, '1);
      issue(OP_DEQUEUE, '0);
      issue(OP_DEQUEUE, '0);

      // Random part in phases: no gaps, mostly idle, lightly idle, and so on.
      while (items_sent < ITEM_TARGET) begin
         idle_percent = idle_plan[(items_sent * 5) / ITEM_TARGET];
         random_burst();
      end
      @(negedge clock);
      start <= 1'b0;

      // Drain, then give a searching item time to show anything stray.
      while (predictor.pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (QUEUE_DEPTH + 4) @(posedge clock);

      if (predictor.mismatches == 0) begin
         $display("PASS fifo_queue_with_search");
      end else begin
         $display("FAIL fifo_queue_with_search");
      end
      $finish;
   end

   // Backstop for a hung handshake: far beyond the slowest legal run.
   initial begin
      #20ms;
      $display("FAIL fifo_queue_with_search");
      $finish;
   end

endmodule
